// File: rtl/ctl_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the C token lexer.
// No dependencies; every lexer file but ctl_stream_if imports this package.
package ctl_pkg;

    localparam int MAX_TEXT  = 1024;
    localparam int LEN_LIMIT = ((MAX_TEXT - 1) < 1023) ? (MAX_TEXT - 1) : 1023;
    localparam logic [9:0] LEN_MAX = 10'(LEN_LIMIT);

    // Result queue sizing: one byte pushes up to two results.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int PUSH_MAX    = 2;

    // result_kind codes
    localparam logic [1:0] RK_CHAR  = 2'd0;
    localparam logic [1:0] RK_TOKEN = 2'd1;
    localparam logic [1:0] RK_ERROR = 2'd2;

    // token_kind codes
    localparam logic [3:0] TK_END    = 4'd0;
    localparam logic [3:0] TK_NUMBER = 4'd1;
    localparam logic [3:0] TK_IDENT  = 4'd2;
    localparam logic [3:0] TK_CHAR   = 4'd3;
    localparam logic [3:0] TK_STRING = 4'd4;
    localparam logic [3:0] TK_ARROW  = 4'd5;
    localparam logic [3:0] TK_LE     = 4'd6;
    localparam logic [3:0] TK_GE     = 4'd7;
    localparam logic [3:0] TK_EQ     = 4'd8;
    localparam logic [3:0] TK_NE     = 4'd9;
    localparam logic [3:0] TK_ANDAND = 4'd10;
    localparam logic [3:0] TK_OROR   = 4'd11;
    localparam logic [3:0] TK_VARARG = 4'd12;
    localparam logic [3:0] TK_DOTDOT = 4'd13;
    localparam logic [3:0] TK_SINGLE = 4'd14;

    // error_code values
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_UNTERM   = 2'd1;
    localparam logic [1:0] ERR_BAD_ESC  = 2'd2;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [3:0] token_kind;
        logic [7:0] token_byte;
        logic [9:0] text_length;
        logic [9:0] literal_length;
        logic       at_line_start;
        logic       space_before;
        logic [1:0] error_code;
        logic       last;
    } t_result;

    // Results of one scanned byte, handed from the scanner to the queue.
    typedef struct packed {
        logic [1:0] count;
        t_result    res1;
        t_result    res0;
    } t_push;

endpackage

// File: rtl/ctl_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the lexer: source bytes in, results out.
// No dependencies.
interface ctl_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface ctl_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] result_kind;
    logic [3:0] token_kind;
    logic [7:0] token_byte;
    logic [9:0] text_length;
    logic [9:0] literal_length;
    logic       at_line_start;
    logic       space_before;
    logic [1:0] error_code;
    logic       last;

    modport source (output valid, output result_kind, output token_kind,
                    output token_byte, output text_length, output literal_length,
                    output at_line_start, output space_before, output error_code,
                    output last, input ready);
    modport sink (input valid, input result_kind, input token_kind,
                  input token_byte, input text_length, input literal_length,
                  input at_line_start, input space_before, input error_code,
                  input last, output ready);
endinterface

// File: rtl/c_token_lexer.sv
`timescale 1ns / 1ps
// Top level of the streaming C lexer: input register, scanner, result queue.
// Depends on ctl_pkg, ctl_stream_if, ctl_scanner and ctl_result_queue.

// The lexer takes one source byte per transfer (byte 0 ends the text) and
// scans it, once the queue has room, between the input register and a
// four-entry result queue. While the output stays ready it sustains one
// byte per cycle as long as each byte gives at most one result; a byte that
// gives two results (a token closed by the next byte that itself is a single
// token or the end, or a string's closing quote) takes two transfers of the
// output port, and the queue absorbs that. The input stalls only when the
// queue holds more than two results.
module c_token_lexer (
    input  logic i_clk,
    input  logic i_rst_n,
    ctl_byte_if.sink     i_in,
    ctl_result_if.source o_res
);
    import ctl_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       step;
    logic       room;
    logic       accept;
    t_push      push;
    t_result    head;

    assign step       = r_in_valid && room;
    assign i_in.ready = !r_in_valid || step;
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept || (r_in_valid && !step);
        end
    end

    // Hold the byte until the scanner takes it.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_in.in_byte;
        end
    end

    ctl_scanner u_scanner (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .o_push  (push)
    );

    ctl_result_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (o_res.ready),
        .o_room  (room),
        .o_valid (o_res.valid),
        .o_data  (head)
    );

    assign o_res.result_kind    = head.result_kind;
    assign o_res.token_kind     = head.token_kind;
    assign o_res.token_byte     = head.token_byte;
    assign o_res.text_length    = head.text_length;
    assign o_res.literal_length = head.literal_length;
    assign o_res.at_line_start  = head.at_line_start;
    assign o_res.space_before   = head.space_before;
    assign o_res.error_code     = head.error_code;
    assign o_res.last           = head.last;

endmodule

// File: rtl/ctl_scanner.sv
`timescale 1ns / 1ps
// Lexer state and the per-byte scan step: up to two results per byte.
// Depends on ctl_pkg.
module ctl_scanner (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_step,
    input  logic [7:0]     i_byte,
    output ctl_pkg::t_push o_push
);
    import ctl_pkg::*;

    typedef enum logic [3:0] {
        M_IDLE, M_NUMBER, M_IDENT, M_OP, M_DOT1, M_DOT2,
        M_CHAR, M_CHAR_ESC, M_STR, M_STR_ESC
    } t_lex_mode;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_N      = 8'h6E;

    t_lex_mode  r_mode, n_mode;
    logic [7:0] r_pend, n_pend;
    logic [9:0] r_raw, n_raw;
    logic [9:0] r_dec, n_dec;
    logic       r_ls, n_ls;
    logic       r_sp, n_sp;

    t_result    res [PUSH_MAX];
    logic [1:0] cnt;
    logic       do_start;
    logic       is_str;
    logic [3:0] lit_kind;
    logic [3:0] pk;
    logic [9:0] raw_inc;
    logic [7:0] dch;
    logic       esc_ok;

    function automatic logic [9:0] sat_inc(input logic [9:0] x);
        return (x < LEN_MAX) ? x + 10'd1 : x;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0B) ||
               (c == 8'h0C) || (c == 8'h0D);
    endfunction

    function automatic logic is_op(input logic [7:0] c);
        return (c == 8'h2D) || (c == 8'h3C) || (c == 8'h3E) || (c == 8'h3D) ||
               (c == 8'h21) || (c == 8'h26) || (c == 8'h7C);
    endfunction

    function automatic logic [3:0] pair_kind(input logic [7:0] a, input logic [7:0] b);
        logic [3:0] k;
        k = TK_END;
        if (a == 8'h2D && b == 8'h3E) k = TK_ARROW;
        if (a == 8'h3C && b == 8'h3D) k = TK_LE;
        if (a == 8'h3E && b == 8'h3D) k = TK_GE;
        if (a == 8'h3D && b == 8'h3D) k = TK_EQ;
        if (a == 8'h21 && b == 8'h3D) k = TK_NE;
        if (a == 8'h26 && b == 8'h26) k = TK_ANDAND;
        if (a == 8'h7C && b == 8'h7C) k = TK_OROR;
        return k;
    endfunction

    function automatic t_result mk_res(input logic [1:0] rk, input logic [3:0] tk,
                                       input logic [7:0] b, input logic [9:0] tl,
                                       input logic [9:0] ll, input logic ls,
                                       input logic sp, input logic [1:0] err);
        t_result r;
        r.result_kind    = rk;
        r.token_kind     = tk;
        r.token_byte     = b;
        r.text_length    = tl;
        r.literal_length = ll;
        r.at_line_start  = ls;
        r.space_before   = sp;
        r.error_code     = err;
        r.last           = 1'b0;
        return r;
    endfunction

    always_comb begin
        n_mode   = r_mode;
        n_pend   = r_pend;
        n_raw    = r_raw;
        n_dec    = r_dec;
        n_ls     = r_ls;
        n_sp     = r_sp;
        res[0]   = '0;
        res[1]   = '0;
        cnt      = 2'd0;
        do_start = 1'b0;
        is_str   = (r_mode == M_STR) || (r_mode == M_STR_ESC);
        lit_kind = is_str ? TK_STRING : TK_CHAR;
        pk       = pair_kind(r_pend, i_byte);
        raw_inc  = sat_inc(r_raw);
        dch      = i_byte;
        esc_ok   = 1'b1;
        if (i_byte == CH_ZERO) begin
            dch = CH_NUL;
        end else if (i_byte == CH_N) begin
            dch = CH_NL;
        end else if (i_byte != CH_SQUOTE && i_byte != CH_DQUOTE && i_byte != CH_BSLASH) begin
            esc_ok = 1'b0;
        end

        // Phase one: finish or extend the open token.
        case (r_mode)
            M_IDLE: begin
                do_start = 1'b1;
            end
            M_NUMBER, M_IDENT: begin
                if (is_digit(i_byte) ||
                    (r_mode == M_IDENT && (is_alpha(i_byte) || i_byte == CH_UNDER))) begin
                    n_raw = raw_inc;
                end else begin
                    res[0] = mk_res(RK_TOKEN, (r_mode == M_NUMBER) ? TK_NUMBER : TK_IDENT,
                                    8'd0, r_raw, 10'd0, r_ls, r_sp, ERR_NONE);
                    cnt      = 2'd1;
                    do_start = 1'b1;
                end
            end
            M_OP: begin
                if (pk != TK_END) begin
                    res[0] = mk_res(RK_TOKEN, pk, 8'd0, 10'd2, 10'd0, r_ls, r_sp, ERR_NONE);
                end else begin
                    res[0] = mk_res(RK_TOKEN, TK_SINGLE, r_pend, 10'd1, 10'd0,
                                    r_ls, r_sp, ERR_NONE);
                    do_start = 1'b1;
                end
                cnt = 2'd1;
            end
            M_DOT1: begin
                if (i_byte == CH_DOT) begin
                    n_mode = M_DOT2;
                    n_raw  = 10'd2;
                end else begin
                    res[0] = mk_res(RK_TOKEN, TK_SINGLE, CH_DOT, 10'd1, 10'd0,
                                    r_ls, r_sp, ERR_NONE);
                    cnt      = 2'd1;
                    do_start = 1'b1;
                end
            end
            M_DOT2: begin
                if (i_byte == CH_DOT) begin
                    res[0] = mk_res(RK_TOKEN, TK_VARARG, 8'd0, 10'd3, 10'd0,
                                    r_ls, r_sp, ERR_NONE);
                end else begin
                    res[0] = mk_res(RK_TOKEN, TK_DOTDOT, 8'd0, 10'd2, 10'd0,
                                    r_ls, r_sp, ERR_NONE);
                    do_start = 1'b1;
                end
                cnt = 2'd1;
            end
            M_CHAR, M_STR: begin
                if (i_byte == (is_str ? CH_DQUOTE : CH_SQUOTE)) begin
                    // Closing quote: a string also yields its trailing NUL.
                    if (is_str) begin
                        n_dec  = sat_inc(r_dec);
                        res[0] = mk_res(RK_CHAR, TK_STRING, CH_NUL, raw_inc, n_dec,
                                        r_ls, r_sp, ERR_NONE);
                        res[1] = mk_res(RK_TOKEN, TK_STRING, 8'd0, raw_inc, n_dec,
                                        r_ls, r_sp, ERR_NONE);
                        cnt = 2'd2;
                    end else begin
                        res[0] = mk_res(RK_TOKEN, TK_CHAR, 8'd0, raw_inc, r_dec,
                                        r_ls, r_sp, ERR_NONE);
                        cnt = 2'd1;
                    end
                    n_mode = M_IDLE;
                    n_raw  = 10'd0;
                    n_dec  = 10'd0;
                    n_pend = 8'd0;
                    n_ls   = 1'b0;
                    n_sp   = 1'b0;
                end else if (i_byte == CH_NUL || i_byte == CH_NL) begin
                    res[0] = mk_res(RK_ERROR, lit_kind, 8'd0, r_raw, r_dec,
                                    r_ls, r_sp, ERR_UNTERM);
                    cnt    = 2'd1;
                    n_mode = M_IDLE;
                    n_raw  = 10'd0;
                    n_dec  = 10'd0;
                    n_pend = 8'd0;
                    n_ls   = 1'b1;
                    n_sp   = 1'b0;
                end else if (i_byte == CH_BSLASH) begin
                    n_raw  = raw_inc;
                    n_mode = is_str ? M_STR_ESC : M_CHAR_ESC;
                end else begin
                    n_raw  = raw_inc;
                    n_dec  = sat_inc(r_dec);
                    res[0] = mk_res(RK_CHAR, lit_kind, i_byte, raw_inc, n_dec,
                                    r_ls, r_sp, ERR_NONE);
                    cnt = 2'd1;
                end
            end
            M_CHAR_ESC, M_STR_ESC: begin
                if (i_byte == CH_NUL || !esc_ok) begin
                    res[0] = mk_res(RK_ERROR, lit_kind, 8'd0,
                                    (i_byte == CH_NUL) ? r_raw : raw_inc, r_dec,
                                    r_ls, r_sp,
                                    (i_byte == CH_NUL) ? ERR_UNTERM : ERR_BAD_ESC);
                    cnt    = 2'd1;
                    n_mode = M_IDLE;
                    n_raw  = 10'd0;
                    n_dec  = 10'd0;
                    n_pend = 8'd0;
                    n_ls   = 1'b1;
                    n_sp   = 1'b0;
                end else begin
                    n_raw  = raw_inc;
                    n_dec  = sat_inc(r_dec);
                    n_mode = is_str ? M_STR : M_CHAR;
                    res[0] = mk_res(RK_CHAR, lit_kind, dch, raw_inc, n_dec,
                                    r_ls, r_sp, ERR_NONE);
                    cnt = 2'd1;
                end
            end
            default: begin
                n_mode   = M_IDLE;
                do_start = 1'b1;
            end
        endcase

        // A finished token clears the marks and goes idle.
        if (cnt != 2'd0 && r_mode != M_IDLE) begin
            n_mode = (n_mode == M_CHAR || n_mode == M_STR) ? n_mode : M_IDLE;
            if (res[0].result_kind == RK_TOKEN) begin
                n_raw  = 10'd0;
                n_dec  = 10'd0;
                n_pend = 8'd0;
                n_ls   = 1'b0;
                n_sp   = 1'b0;
            end
        end

        // Phase two: scan the byte as the start of a new token.
        if (do_start) begin
            if (i_byte == CH_NUL) begin
                res[cnt[0]] = mk_res(RK_TOKEN, TK_END, 8'd0, 10'd0, 10'd0,
                                     1'b1, n_sp, ERR_NONE);
                cnt    = cnt + 2'd1;
                n_mode = M_IDLE;
                n_raw  = 10'd0;
                n_dec  = 10'd0;
                n_pend = 8'd0;
                n_ls   = 1'b1;
                n_sp   = 1'b0;
            end else if (i_byte == CH_NL) begin
                n_ls = 1'b1;
                n_sp = 1'b1;
            end else if (is_space(i_byte)) begin
                n_sp = 1'b1;
            end else if (i_byte == CH_SQUOTE || i_byte == CH_DQUOTE) begin
                n_mode = (i_byte == CH_SQUOTE) ? M_CHAR : M_STR;
                n_raw  = 10'd1;
                n_dec  = 10'd0;
            end else if (is_digit(i_byte)) begin
                n_mode = M_NUMBER;
                n_raw  = 10'd1;
            end else if (is_alpha(i_byte) || i_byte == CH_UNDER) begin
                n_mode = M_IDENT;
                n_raw  = 10'd1;
            end else if (is_op(i_byte)) begin
                n_mode = M_OP;
                n_pend = i_byte;
                n_raw  = 10'd1;
            end else if (i_byte == CH_DOT) begin
                n_mode = M_DOT1;
                n_raw  = 10'd1;
            end else begin
                res[cnt[0]] = mk_res(RK_TOKEN, TK_SINGLE, i_byte, 10'd1, 10'd0,
                                     n_ls, n_sp, ERR_NONE);
                cnt    = cnt + 2'd1;
                n_mode = M_IDLE;
                n_raw  = 10'd0;
                n_dec  = 10'd0;
                n_pend = 8'd0;
                n_ls   = 1'b0;
                n_sp   = 1'b0;
            end
        end

        if (cnt == 2'd1) begin
            res[0].last = 1'b1;
        end else if (cnt == 2'd2) begin
            res[1].last = 1'b1;
        end

        o_push.count = i_step ? cnt : 2'd0;
        o_push.res0  = res[0];
        o_push.res1  = res[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_pend <= 8'd0;
            r_raw  <= 10'd0;
            r_dec  <= 10'd0;
            r_ls   <= 1'b1;
            r_sp   <= 1'b0;
        end else if (i_step) begin
            r_mode <= n_mode;
            r_pend <= n_pend;
            r_raw  <= n_raw;
            r_dec  <= n_dec;
            r_ls   <= n_ls;
            r_sp   <= n_sp;
        end
    end

endmodule

// File: rtl/ctl_result_queue.sv
`timescale 1ns / 1ps
// Small result queue: takes up to two results per cycle, gives one per transfer.
// Depends on ctl_pkg.
module ctl_result_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ctl_pkg::t_push   i_push,
    input  logic             i_pop,
    output logic             o_room,
    output logic             o_valid,
    output ctl_pkg::t_result o_data
);
    import ctl_pkg::*;

    t_result               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wptr, n_wptr;
    logic [QUEUE_AW-1:0]   r_rptr, n_rptr;
    logic [QUEUE_AW:0]     r_count, n_count;
    logic                  pop;
    logic [QUEUE_AW-1:0]   wptr_1;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    // Leave room for the worst case of one byte.
    assign o_room  = (r_count <= (QUEUE_AW + 1)'(QUEUE_DEPTH - PUSH_MAX));
    assign pop     = i_pop && o_valid;
    assign wptr_1  = r_wptr + QUEUE_AW'(1);

    always_comb begin
        n_wptr  = r_wptr + QUEUE_AW'(i_push.count);
        n_rptr  = pop ? r_rptr + QUEUE_AW'(1) : r_rptr;
        n_count = r_count + (QUEUE_AW + 1)'(i_push.count) - (QUEUE_AW + 1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wptr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wptr_1] <= i_push.res1;
        end
    end

endmodule

// File: bench/ctl_lexer_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the C token lexer: models the tokenizer on every byte transfer
// and compares each result transfer with the oldest predicted result.
// Depends on ctl_pkg and the channel interfaces in ctl_stream_if.
module ctl_lexer_checker (
    input  logic   i_clk,
    input  logic   i_rst_n,
    ctl_byte_if    i_bytes,
    ctl_result_if  i_results,
    output int     o_fail_count,
    output int     o_pending
);
    import ctl_pkg::*;

    localparam logic [7:0] CH_NL = 8'h0A;
    localparam logic [7:0] CH_VT = 8'h0B;
    localparam logic [7:0] CH_FF = 8'h0C;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam int SHOW_MAX = 10;

    typedef enum logic [3:0] {
        LM_IDLE, LM_NUMBER, LM_IDENT, LM_OP, LM_DOT1, LM_DOT2,
        LM_CHAR, LM_CHAR_ESC, LM_STR, LM_STR_ESC
    } lex_mode_e;

    lex_mode_e  mode;
    logic [7:0] op_first;
    logic [9:0] raw_len;
    logic [9:0] dec_len;
    logic       line_mark;
    logic       space_mark;

    t_result    byte_res [PUSH_MAX];
    int         byte_res_n;
    t_result    pending_results [$];
    int         fail_total;

    function automatic logic [9:0] bump(input logic [9:0] x);
        return (x < LEN_MAX) ? x + 10'd1 : x;
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_space(input logic [7:0] c);
        return c == " " || c == "\t" || c == CH_NL || c == CH_VT || c == CH_FF
            || c == CH_CR;
    endfunction

    function automatic logic [3:0] pair_kind(input logic [7:0] a, input logic [7:0] b);
        if (a == "-" && b == ">") return TK_ARROW;
        if (a == "<" && b == "=") return TK_LE;
        if (a == ">" && b == "=") return TK_GE;
        if (a == "=" && b == "=") return TK_EQ;
        if (a == "!" && b == "=") return TK_NE;
        if (a == "&" && b == "&") return TK_ANDAND;
        if (a == "|" && b == "|") return TK_OROR;
        return TK_END;
    endfunction

    function automatic void clear_lexer();
        mode       = LM_IDLE;
        op_first   = 8'd0;
        raw_len    = 10'd0;
        dec_len    = 10'd0;
        line_mark  = 1'b1;
        space_mark = 1'b0;
    endfunction

    function automatic void emit(input logic [1:0] rk, input logic [3:0] tk,
                                 input logic [7:0] b, input logic [9:0] tl,
                                 input logic [9:0] ll, input logic [1:0] err);
        t_result r;
        if (byte_res_n >= PUSH_MAX) return;
        r.result_kind    = rk;
        r.token_kind     = tk;
        r.token_byte     = b;
        r.text_length    = tl;
        r.literal_length = ll;
        r.at_line_start  = line_mark;
        r.space_before   = space_mark;
        r.error_code     = err;
        r.last           = 1'b0;
        byte_res[byte_res_n] = r;
        byte_res_n++;
    endfunction

    function automatic void close_token(input logic [3:0] tk, input logic [7:0] b,
                                        input logic [9:0] tl, input logic [9:0] ll);
        emit(RK_TOKEN, tk, b, tl, ll, ERR_NONE);
        mode       = LM_IDLE;
        raw_len    = 10'd0;
        dec_len    = 10'd0;
        op_first   = 8'd0;
        line_mark  = 1'b0;
        space_mark = 1'b0;
    endfunction

    function automatic void literal_fail(input logic [1:0] code);
        logic [3:0] tk;
        tk = (mode == LM_STR || mode == LM_STR_ESC) ? TK_STRING : TK_CHAR;
        emit(RK_ERROR, tk, 8'd0, raw_len, dec_len, code);
        clear_lexer();
    endfunction

    function automatic void start_token(input logic [7:0] c);
        if (c == 8'd0) begin
            line_mark = 1'b1;
            emit(RK_TOKEN, TK_END, 8'd0, 10'd0, 10'd0, ERR_NONE);
            clear_lexer();
        end else if (c == CH_NL) begin
            line_mark  = 1'b1;
            space_mark = 1'b1;
        end else if (is_space(c)) begin
            space_mark = 1'b1;
        end else if (c == "'" || c == "\"") begin
            mode    = (c == "'") ? LM_CHAR : LM_STR;
            raw_len = 10'd1;
            dec_len = 10'd0;
        end else if (is_digit(c)) begin
            mode    = LM_NUMBER;
            raw_len = 10'd1;
        end else if (is_alpha(c) || c == "_") begin
            mode    = LM_IDENT;
            raw_len = 10'd1;
        end else if (c == "-" || c == "<" || c == ">" || c == "=" || c == "!"
                     || c == "&" || c == "|") begin
            mode     = LM_OP;
            op_first = c;
            raw_len  = 10'd1;
        end else if (c == ".") begin
            mode    = LM_DOT1;
            raw_len = 10'd1;
        end else begin
            close_token(TK_SINGLE, c, 10'd1, 10'd0);
        end
    endfunction

    function automatic void literal_byte(input logic [7:0] c, input bit is_str);
        logic [3:0] tk;
        tk = is_str ? TK_STRING : TK_CHAR;
        if (c == (is_str ? 8'h22 : 8'h27)) begin
            raw_len = bump(raw_len);
            // a string closes with a decoded NUL of its own
            if (is_str) begin
                dec_len = bump(dec_len);
                emit(RK_CHAR, tk, 8'd0, raw_len, dec_len, ERR_NONE);
            end
            close_token(tk, 8'd0, raw_len, dec_len);
        end else if (c == 8'd0 || c == CH_NL) begin
            literal_fail(ERR_UNTERM);
        end else if (c == "\\") begin
            raw_len = bump(raw_len);
            mode    = is_str ? LM_STR_ESC : LM_CHAR_ESC;
        end else begin
            raw_len = bump(raw_len);
            dec_len = bump(dec_len);
            emit(RK_CHAR, tk, c, raw_len, dec_len, ERR_NONE);
        end
    endfunction

    function automatic void escape_byte(input logic [7:0] c, input bit is_str);
        logic [7:0] d;
        if (c == 8'd0) begin
            literal_fail(ERR_UNTERM);
            return;
        end
        raw_len = bump(raw_len);
        if (c == "0") d = 8'd0;
        else if (c == "n") d = CH_NL;
        else if (c == "'" || c == "\"" || c == "\\") d = c;
        else begin
            literal_fail(ERR_BAD_ESC);
            return;
        end
        dec_len = bump(dec_len);
        mode    = is_str ? LM_STR : LM_CHAR;
        emit(RK_CHAR, is_str ? TK_STRING : TK_CHAR, d, raw_len, dec_len, ERR_NONE);
    endfunction

    function automatic void lex_byte(input logic [7:0] c);
        logic [3:0] k;
        byte_res_n = 0;
        case (mode)
            LM_NUMBER: begin
                if (is_digit(c)) raw_len = bump(raw_len);
                else begin
                    close_token(TK_NUMBER, 8'd0, raw_len, 10'd0);
                    start_token(c);
                end
            end
            LM_IDENT: begin
                if (is_alpha(c) || is_digit(c) || c == "_") raw_len = bump(raw_len);
                else begin
                    close_token(TK_IDENT, 8'd0, raw_len, 10'd0);
                    start_token(c);
                end
            end
            LM_OP: begin
                k = pair_kind(op_first, c);
                if (k != TK_END) close_token(k, 8'd0, 10'd2, 10'd0);
                else begin
                    close_token(TK_SINGLE, op_first, 10'd1, 10'd0);
                    start_token(c);
                end
            end
            LM_DOT1: begin
                if (c == ".") begin
                    mode    = LM_DOT2;
                    raw_len = 10'd2;
                end else begin
                    close_token(TK_SINGLE, ".", 10'd1, 10'd0);
                    start_token(c);
                end
            end
            LM_DOT2: begin
                if (c == ".") close_token(TK_VARARG, 8'd0, 10'd3, 10'd0);
                else begin
                    close_token(TK_DOTDOT, 8'd0, 10'd2, 10'd0);
                    start_token(c);
                end
            end
            LM_CHAR:     literal_byte(c, 1'b0);
            LM_STR:      literal_byte(c, 1'b1);
            LM_CHAR_ESC: escape_byte(c, 1'b0);
            LM_STR_ESC:  escape_byte(c, 1'b1);
            default: begin
                mode = LM_IDLE;
                start_token(c);
            end
        endcase
        if (byte_res_n > 0) byte_res[byte_res_n - 1].last = 1'b1;
        for (int i = 0; i < byte_res_n; i++) pending_results.push_back(byte_res[i]);
    endfunction

    function automatic string show(input t_result r);
        return $sformatf({"kind=%0d tok=%0d byte=%02h text=%0d lit=%0d",
                          " ls=%0b sp=%0b err=%0d last=%0b"},
                         r.result_kind, r.token_kind, r.token_byte, r.text_length,
                         r.literal_length, r.at_line_start, r.space_before,
                         r.error_code, r.last);
    endfunction

    function automatic void note_fail(input string msg);
        fail_total++;
        if (fail_total <= SHOW_MAX) $display("%0t ns: %s", $realtime, msg);
    endfunction

    initial begin
        fail_total   = 0;
        o_fail_count = 0;
        o_pending    = 0;
        clear_lexer();
    end

    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            clear_lexer();
            pending_results.delete();
        end else begin
            if (i_bytes.valid && i_bytes.ready) lex_byte(i_bytes.in_byte);
            if (i_results.valid && i_results.ready) begin
                got.result_kind    = i_results.result_kind;
                got.token_kind     = i_results.token_kind;
                got.token_byte     = i_results.token_byte;
                got.text_length    = i_results.text_length;
                got.literal_length = i_results.literal_length;
                got.at_line_start  = i_results.at_line_start;
                got.space_before   = i_results.space_before;
                got.error_code     = i_results.error_code;
                got.last           = i_results.last;
                if (pending_results.size() == 0) begin
                    note_fail({"unexpected result: ", show(got)});
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want)
                        note_fail({"mismatch: expected ", show(want), " got ", show(got)});
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= pending_results.size();
    end

endmodule

// File: bench/c_token_lexer_tb.sv
`timescale 1ns / 1ps
// Top of the C token lexer bench: clock, reset, source text and result stalls.
// Depends on ctl_pkg, ctl_stream_if, c_token_lexer and ctl_lexer_checker.
module c_token_lexer_tb;
    import ctl_pkg::*;

    localparam logic [7:0] CH_NL = 8'h0A;
    localparam int RANDOM_ITEMS = 670;
    localparam int CALM_TAIL    = 100;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    bit   src_idle_en;
    bit   sink_idle_en;

    logic [7:0] text_q [$];
    string      op_pairs [7] = '{"->", "<=", ">=", "==", "!=", "&&", "||"};

    ctl_byte_if   byte_ch ();
    ctl_result_if res_ch ();

    c_token_lexer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch),
        .o_res   (res_ch)
    );

    ctl_lexer_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_bytes      (byte_ch),
        .i_results    (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [7:0] pick(input string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    function automatic void add_str(input string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endfunction

    // Plain literal content: anything but the closing quote, backslash, newline or NUL.
    function automatic void add_plain(input logic [7:0] quote);
        logic [7:0] b;
        b = 8'($urandom_range(1, 255));
        while (b == quote || b == "\\" || b == CH_NL) b = 8'($urandom_range(1, 255));
        text_q.push_back(b);
    endfunction

    function automatic void add_literal_body(input logic [7:0] quote, input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                text_q.push_back("\\");
                text_q.push_back(pick("0n'\"\\"));
            end else begin
                add_plain(quote);
            end
        end
    endfunction

    function automatic void add_broken_literal();
        logic [7:0] quote;
        logic [7:0] b;
        quote = ($urandom_range(0, 1) == 0) ? 8'h27 : 8'h22;
        text_q.push_back(quote);
        add_literal_body(quote, $urandom_range(0, 3));
        case ($urandom_range(0, 3))
            0: text_q.push_back(CH_NL);
            1: text_q.push_back(8'd0);
            2: begin
                text_q.push_back("\\");
                text_q.push_back(8'd0);
            end
            default: begin
                text_q.push_back("\\");
                if ($urandom_range(0, 2) == 0) b = CH_NL;
                else begin
                    b = 8'($urandom_range(1, 255));
                    while (b == "0" || b == "n" || b == "'" || b == "\"" || b == "\\")
                        b = 8'($urandom_range(1, 255));
                end
                text_q.push_back(b);
            end
        endcase
    endfunction

    function automatic void add_token();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            text_q.push_back(pick({" \t", 8'h0A, 8'h0B, 8'h0C, 8'h0D}));
        end else if (r < 24) begin
            n = $urandom_range(1, 5);
            for (int i = 0; i < n; i++) text_q.push_back(pick("0123456789"));
        end else if (r < 38) begin
            text_q.push_back(pick("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_"));
            n = $urandom_range(0, 5);
            for (int i = 0; i < n; i++)
                text_q.push_back(pick("abcxyzABCXYZ_0123456789"));
        end else if (r < 50) begin
            if ($urandom_range(0, 1) == 0) add_str(op_pairs[$urandom_range(0, 6)]);
            else text_q.push_back(pick("-<>=!&|"));
        end else if (r < 58) begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) text_q.push_back(".");
        end else if (r < 68) begin
            text_q.push_back(8'h27);
            add_literal_body(8'h27, $urandom_range(0, 2));
            text_q.push_back(8'h27);
        end else if (r < 80) begin
            text_q.push_back(8'h22);
            add_literal_body(8'h22, $urandom_range(0, 6));
            text_q.push_back(8'h22);
        end else if (r < 90) begin
            text_q.push_back(8'($urandom_range(1, 255)));
        end else if (r < 96) begin
            add_broken_literal();
        end else begin
            text_q.push_back(8'd0);
        end
    endfunction

    task automatic send_byte(input logic [7:0] b);
        if (src_idle_en && $urandom_range(0, 7) == 0) begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.in_byte <= b;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_text();
        while (text_q.size() > 0) send_byte(text_q.pop_front());
    endtask

    // Result side: hold ready low in bursts while stalls are enabled.
    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_idle_en && $urandom_range(0, 5) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge i_clk);
            end
            res_ch.ready <= 1'b1;
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready)) quiet = 0;
            else quiet++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        int rand_sent;
        int n;
        rand_sent       = 0;
        src_idle_en     = 1'b0;
        sink_idle_en    = 1'b0;
        byte_ch.valid   <= 1'b0;
        byte_ch.in_byte <= 8'd0;
        i_rst_n         <= 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Most token kinds, empty char, escapes, bad escape, unterminated string, end.
        add_str({8'h0A, "7_Z-><=.....''\"\\n\""});
        text_q.push_back(8'hFF);
        add_str("'\\q\"");
        text_q.push_back(8'd0);
        text_q.push_back(8'd0);
        send_text();

        while (rand_sent < RANDOM_ITEMS) begin
            if (rand_sent >= RANDOM_ITEMS - CALM_TAIL) begin
                src_idle_en  = 1'b0;
                sink_idle_en = 1'b0;
            end else begin
                src_idle_en  = $urandom_range(0, 3) != 0;
                sink_idle_en = $urandom_range(0, 3) != 0;
            end
            n = $urandom_range(2, 12);
            for (int i = 0; i < n; i++) add_token();
            if ($urandom_range(0, 9) != 0) text_q.push_back(8'd0);
            rand_sent += text_q.size();
            send_text();
        end
        byte_ch.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

endmodule
